// ----- sv/sscd_pkg.sv -----
package sscd_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FRAME = 1'b1;

	localparam logic [1:0] CFG_BUTTONS = 2'd0;
	localparam logic [1:0] CFG_FRAMES  = 2'd1;

	localparam logic       BUTTONS_RESET = 1'b1;
	localparam logic [7:0] FRAMES_RESET  = 8'd10;

	localparam logic [3:0] SEL_TENTHS   = 4'h8;
	localparam logic [3:0] SEL_UNITS    = 4'h4;
	localparam logic [3:0] SEL_TENS     = 4'h2;
	localparam logic [3:0] SEL_HUNDREDS = 4'h1;

	typedef struct packed {
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] units;
		logic [3:0] tenths;
		logic       done;
	} frame_t;

	typedef struct packed {
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] units;
	} bcd_t;

	// gfedcba, blank for codes above nine
	function automatic logic [6:0] seg_decode(input logic [3:0] digit);
		logic [6:0] seg;
		case (digit)
			4'd0: seg = 7'h3F;
			4'd1: seg = 7'h06;
			4'd2: seg = 7'h5B;
			4'd3: seg = 7'h4F;
			4'd4: seg = 7'h66;
			4'd5: seg = 7'h6D;
			4'd6: seg = 7'h7D;
			4'd7: seg = 7'h07;
			4'd8: seg = 7'h7F;
			4'd9: seg = 7'h6F;
			default: seg = 7'h00;
		endcase
		return seg;
	endfunction

	function automatic bcd_t bin_to_bcd(input logic [7:0] value);
		bcd_t       res;
		logic [6:0] rem;
		logic [14:0] prod;
		logic [6:0] tens_x10;
		if (value >= 8'd200) begin
			res.hundreds = 4'd2;
			rem = 7'(value - 8'd200);
		end else if (value >= 8'd100) begin
			res.hundreds = 4'd1;
			rem = 7'(value - 8'd100);
		end else begin
			res.hundreds = 4'd0;
			rem = value[6:0];
		end
		// rem / 10 by reciprocal, exact for rem below 100
		prod = 15'(rem) * 15'd205;
		res.tens = prod[14:11];
		tens_x10 = 7'({res.tens, 3'b000}) + 7'({res.tens, 1'b0});
		res.units = 4'(rem - tens_x10);
		return res;
	endfunction

endpackage

// ----- sv/seven_segment_countdown_timer_core.sv -----
// an input item is registered, then a frame moves to the scan register and its
// digit items follow one per cycle while out_stall is low; a frame item waits
// for earlier digits; a load item every cycle unless a frame waits, no result
// reset: digits and prescaler zero, timer finished until loaded,
// buttons enabled, ten frames per step
module seven_segment_countdown_timer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [7:0] start_value,
	input  logic [3:0] clear_n,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] segments,
	output logic [3:0] digit_select,
	output logic       last_digit,
	output logic       done_res,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic       buttons_enabled_q;
	logic [7:0] frames_per_step_q;

	logic       valid_s1;
	logic       opcode_s1;
	logic [7:0] start_value_s1;
	logic [3:0] clear_n_s1;

	logic             can_take;
	logic             advance;
	logic             frame_load;
	sscd_pkg::frame_t frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buttons_enabled_q <= sscd_pkg::BUTTONS_RESET;
			frames_per_step_q <= sscd_pkg::FRAMES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sscd_pkg::CFG_BUTTONS: buttons_enabled_q <= cfg_data[0];
				sscd_pkg::CFG_FRAMES:  frames_per_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// loads never wait, frames wait for the scan register
	assign advance    = valid_s1 && (opcode_s1 == sscd_pkg::OP_LOAD || can_take);
	assign frame_load = advance && opcode_s1 == sscd_pkg::OP_FRAME;
	assign in_stall   = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1      <= opcode;
			start_value_s1 <= start_value;
			clear_n_s1     <= clear_n;
		end
	end

	sscd_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.opcode          (opcode_s1),
		.start_value     (start_value_s1),
		.clear_n         (clear_n_s1),
		.buttons_enabled (buttons_enabled_q),
		.frames_per_step (frames_per_step_q),
		.frame           (frame)
	);

	sscd_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (frame_load),
		.frame        (frame),
		.can_take     (can_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segments     (segments),
		.digit_select (digit_select),
		.last_digit   (last_digit),
		.done_res     (done_res)
	);

endmodule

// ----- sv/sscd_core.sv -----
module sscd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 opcode,
	input  logic [7:0]           start_value,
	input  logic [3:0]           clear_n,
	input  logic                 buttons_enabled,
	input  logic [7:0]           frames_per_step,
	output sscd_pkg::frame_t     frame
);

	logic [3:0] hundreds_q, tens_q, units_q, tenths_q;
	logic [7:0] frame_counter_q;
	logic       finished_q;

	logic       clr_en;
	logic [3:0] h_c, te_c, u_c, t_c;
	logic [3:0] h_n, te_n, u_n, t_n;
	logic [7:0] fc_inc, fc_n;
	logic       hit, fin_n;
	sscd_pkg::bcd_t load_bcd;

	assign load_bcd = sscd_pkg::bin_to_bcd(start_value);

	always_comb begin
		clr_en = !finished_q && buttons_enabled;
		h_c  = (clr_en && !clear_n[0]) ? 4'd0 : hundreds_q;
		te_c = (clr_en && !clear_n[1]) ? 4'd0 : tens_q;
		u_c  = (clr_en && !clear_n[2]) ? 4'd0 : units_q;
		t_c  = (clr_en && !clear_n[3]) ? 4'd0 : tenths_q;

		fc_inc = frame_counter_q + 8'd1;
		hit = !finished_q && (fc_inc == frames_per_step);
		fc_n = finished_q ? frame_counter_q : (hit ? 8'd0 : fc_inc);

		h_n = h_c;
		te_n = te_c;
		u_n = u_c;
		t_n = t_c;
		if (hit) begin
			if (t_c == 4'd0) begin
				// borrow into units, ten minus two
				t_n = 4'd8;
				if (u_c == 4'd0) begin
					u_n = 4'd9;
					if (te_c == 4'd0) begin
						te_n = 4'd9;
						if (h_c != 4'd0) h_n = h_c - 4'd1;
					end else begin
						te_n = te_c - 4'd1;
					end
				end else begin
					u_n = u_c - 4'd1;
				end
			end else begin
				t_n = t_c - 4'd2;
			end
		end

		fin_n = finished_q ||
			(h_n == 4'd0 && te_n == 4'd0 && u_n == 4'd0 && t_n == 4'd0);

		frame.hundreds = h_c;
		frame.tens     = te_c;
		frame.units    = u_c;
		frame.tenths   = t_c;
		frame.done     = fin_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hundreds_q      <= 4'd0;
			tens_q          <= 4'd0;
			units_q         <= 4'd0;
			tenths_q        <= 4'd0;
			frame_counter_q <= 8'd0;
			finished_q      <= 1'b1;
		end else if (step) begin
			if (opcode == sscd_pkg::OP_LOAD) begin
				hundreds_q      <= load_bcd.hundreds;
				tens_q          <= load_bcd.tens;
				units_q         <= load_bcd.units;
				tenths_q        <= 4'd0;
				frame_counter_q <= 8'd0;
				finished_q      <= 1'b0;
			end else begin
				hundreds_q      <= h_n;
				tens_q          <= te_n;
				units_q         <= u_n;
				tenths_q        <= t_n;
				frame_counter_q <= fc_n;
				finished_q      <= fin_n;
			end
		end
	end

endmodule

// ----- sv/sscd_scan.sv -----
module sscd_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sscd_pkg::frame_t frame,
	output logic             can_take,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       segments,
	output logic [3:0]       digit_select,
	output logic             last_digit,
	output logic             done_res
);

	sscd_pkg::frame_t frame_q;
	logic             valid_q;
	logic [1:0]       idx_q;
	logic             out_fire;
	logic [3:0]       digit;

	assign out_valid = valid_q;
	assign out_fire  = valid_q && !out_stall;
	assign can_take  = !valid_q || (out_fire && idx_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (out_fire) begin
			if (idx_q == 2'd3) valid_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) frame_q <= frame;
	end

	// scan order: tenths, units, tens, hundreds
	always_comb begin
		case (idx_q)
			2'd0: begin
				digit = frame_q.tenths;
				digit_select = sscd_pkg::SEL_TENTHS;
			end
			2'd1: begin
				digit = frame_q.units;
				digit_select = sscd_pkg::SEL_UNITS;
			end
			2'd2: begin
				digit = frame_q.tens;
				digit_select = sscd_pkg::SEL_TENS;
			end
			default: begin
				digit = frame_q.hundreds;
				digit_select = sscd_pkg::SEL_HUNDREDS;
			end
		endcase
		segments   = {idx_q == 2'd1, sscd_pkg::seg_decode(digit)};
		last_digit = (idx_q == 2'd3);
		done_res   = frame_q.done;
	end

endmodule
